FILE: design/sacl_pkg.sv
// Package with the shared types and constants of the LRU cache tag store.
`timescale 1ns / 1ps
`default_nettype none

package sacl_pkg;

   // Default geometry of the tag store.
   localparam int DEF_SETS = 16;
   localparam int DEF_WAYS = 4;

   // Operation codes carried in the mode field of an item.
   localparam logic [1:0] MODE_LOOKUP = 2'd0;
   localparam logic [1:0] MODE_FILL   = 2'd1;
   localparam logic [1:0] MODE_INVAL  = 2'd2;
   localparam logic [1:0] MODE_DIRTY  = 2'd3;

   // Configuration register indexes and reset values.
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 4;
   localparam logic [CSR_IDX_W-1:0]  CSR_OFFSET_BITS = 1'd0;
   localparam logic [CSR_IDX_W-1:0]  CSR_INDEX_BITS  = 1'd1;
   localparam logic [CSR_DATA_W-1:0] OFFSET_BITS_RST = 4'd6;
   localparam logic [CSR_DATA_W-1:0] INDEX_BITS_RST  = 4'd4;

   typedef struct packed {
      logic [1:0]  mode;
      logic [3:0]  set_index;
      logic [19:0] tag;
      logic [30:0] stamp;
      logic        dirty_in;
      logic [19:0] page_frame;
      logic [7:0]  l1_index;
      logic [23:0] l1_tag;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic        set_was_full;
      logic        victim_valid;
      logic        victim_dirty;
      logic [31:0] victim_address;
      logic [7:0]  victim_l1_index;
      logic [23:0] victim_l1_tag;
   } rsp_type;

   // One stored line of the tag store.
   typedef struct packed {
      logic        valid;
      logic [19:0] tag;
      logic [30:0] stamp;
      logic        dirty;
      logic [19:0] frame;
      logic [7:0]  l1_index;
      logic [23:0] l1_tag;
   } line_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FILL,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

FILE: design/set_assoc_cache_tag_store_lru.sv
// Top level of the set-associative tag store with timestamp LRU replacement.
//
//   Channel   Direction  Handshake               Payload
//   req_*     in         req_valid / req_stall   sacl_pkg::req_type
//   rsp_*     out        rsp_valid / rsp_stall   sacl_pkg::rsp_type
//   csr_*     in         csr_wr_en               csr_index, csr_wdata
//
// A lookup scans every way of its set, a fill scans its set and then writes the chosen way,
// and an invalidate by page frame walks the whole store; a match ends a mark-dirty or an
// invalidate scan early, and an invalid way ends a fill scan early. Items are paced by the
// single read port of the line memory, which delivers one way per cycle to the shared
// tag, frame and stamp comparators. After reset a clearing pass writes every line to zero,
// during which req_stall stays high. The result sits in an output register, so the next item
// is accepted while a finished result is still stalled.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_cache_tag_store_lru #(
   parameter int SETS = sacl_pkg::DEF_SETS,
   parameter int WAYS = sacl_pkg::DEF_WAYS
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  sacl_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output sacl_pkg::rsp_type                   rsp_data,
   input  wire                                 csr_wr_en,
   input  wire [sacl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire [sacl_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import sacl_pkg::*;

   localparam int LINES = SETS * WAYS;
   // Line address width and a counter width that can also hold LINES itself.
   localparam int LAW = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int LCW = $clog2(LINES + 1);

   // Line memory: one write and one registered read per cycle.
   line_type           mem [LINES];
   logic               mem_we;
   logic [LAW-1:0]     mem_waddr;
   line_type           mem_wdata;
   logic               mem_re;
   logic [LAW-1:0]     mem_raddr;
   line_type           rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   // Control and working registers.
   state_type          state_ff, state_in;
   logic [LCW-1:0]     cnt_ff, cnt_in;           // next line or way to read
   logic [LAW-1:0]     base_ff, base_in;         // first line of the addressed set
   logic               rd_pend_ff, rd_pend_in;   // read data arrives this cycle
   logic [LAW-1:0]     rd_addr_ff, rd_addr_in;   // address of that read data
   logic               rd_last_ff, rd_last_in;   // it is the last line of the scan
   req_type            item_ff, item_in;
   logic               hit_ff, hit_in;
   logic               full_ff, full_in;
   logic               have_ff, have_in;         // a candidate victim was seen
   logic               inv_ff, inv_in;           // an invalid way was found
   logic [30:0]        best_ff, best_in;
   logic [LAW-1:0]     vic_addr_ff, vic_addr_in;
   line_type           vic_line_ff, vic_line_in;
   logic [3:0]         offset_bits_ff, offset_bits_in;
   logic [3:0]         index_bits_ff, index_bits_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // Scan helpers.
   logic [LCW-1:0]     scan_len;
   logic               issue;
   logic               done;
   logic               tag_match;
   logic               frame_match;
   logic               older;
   logic               set_ok;
   logic [4:0]         addr_shift;
   logic [31:0]        vic_address;
   line_type           upd_line;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An invalidate walks the whole store; every other operation walks one set.
   assign scan_len    = (item_ff.mode == MODE_INVAL) ? LCW'(LINES) : LCW'(WAYS);
   assign tag_match   = rdata_ff.valid && (rdata_ff.tag == item_ff.tag);
   assign frame_match = rdata_ff.valid && (rdata_ff.frame == item_ff.page_frame);
   assign older       = rdata_ff.stamp < best_ff;
   assign set_ok      = 32'(req_data.set_index) < SETS;

   // Rebuild the victim's physical base from its tag and set; only 32 bits survive.
   assign addr_shift  = {1'b0, index_bits_ff} + {1'b0, offset_bits_ff};
   assign vic_address = ({12'd0, vic_line_ff.tag} << addr_shift) |
                        ({28'd0, item_ff.set_index} << offset_bits_ff);

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      base_in        = base_ff;
      rd_pend_in     = 1'b0;
      rd_addr_in     = rd_addr_ff;
      rd_last_in     = rd_last_ff;
      item_in        = item_ff;
      hit_in         = hit_ff;
      full_in        = full_ff;
      have_in        = have_ff;
      inv_in         = inv_ff;
      best_in        = best_ff;
      vic_addr_in    = vic_addr_ff;
      vic_line_in    = vic_line_ff;
      offset_bits_in = offset_bits_ff;
      index_bits_in  = index_bits_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      mem_we         = 1'b0;
      mem_waddr      = rd_addr_ff;
      mem_wdata      = '0;
      mem_re         = 1'b0;
      mem_raddr      = base_ff + cnt_ff[LAW-1:0];
      issue          = 1'b0;
      done           = 1'b0;
      upd_line       = rdata_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_OFFSET_BITS: offset_bits_in = csr_wdata;
            CSR_INDEX_BITS:  index_bits_in  = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         // Sweep zeros through the memory, one line per cycle.
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff[LAW-1:0];
            mem_wdata = '0;
            if (cnt_ff == LCW'(LINES - 1)) begin
               state_in = ST_IDLE;
            end
            cnt_in = cnt_ff + LCW'(1);
         end

         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               cnt_in  = '0;
               hit_in  = 1'b0;
               full_in = 1'b0;
               have_in = 1'b0;
               inv_in  = 1'b0;
               best_in = '0;
               if (req_data.mode == MODE_INVAL) begin
                  base_in  = '0;
                  state_in = ST_SCAN;
               end else if (set_ok) begin
                  base_in  = LAW'(req_data.set_index * WAYS);
                  state_in = ST_SCAN;
               end else begin
                  // A set beyond the store is ignored and answers all zero.
                  state_in = ST_RESP;
               end
            end
         end

         // Reads go out one per cycle; each returned line is judged the cycle after.
         ST_SCAN: begin
            if (rd_pend_ff) begin
               unique case (item_ff.mode)
                  MODE_LOOKUP: begin
                     if (tag_match) begin
                        upd_line.stamp = item_ff.stamp;
                        mem_we         = 1'b1;
                        mem_wdata      = upd_line;
                        hit_in         = 1'b1;
                     end
                     done = rd_last_ff;
                  end
                  MODE_DIRTY: begin
                     if (tag_match) begin
                        upd_line.dirty = 1'b1;
                        mem_we         = 1'b1;
                        mem_wdata      = upd_line;
                        done           = 1'b1;
                     end else begin
                        done = rd_last_ff;
                     end
                  end
                  MODE_INVAL: begin
                     if (frame_match) begin
                        mem_we    = 1'b1;
                        mem_wdata = '0;
                        hit_in    = 1'b1;
                        done      = 1'b1;
                     end else begin
                        done = rd_last_ff;
                     end
                  end
                  MODE_FILL: begin
                     // First invalid way wins; otherwise the first smallest stamp.
                     if (!rdata_ff.valid) begin
                        inv_in      = 1'b1;
                        vic_addr_in = rd_addr_ff;
                        done        = 1'b1;
                     end else begin
                        if (!have_ff || older) begin
                           have_in     = 1'b1;
                           best_in     = rdata_ff.stamp;
                           vic_addr_in = rd_addr_ff;
                           vic_line_in = rdata_ff;
                        end
                        done = rd_last_ff;
                     end
                  end
                  default: ;
               endcase
            end

            issue = !done && (cnt_ff < scan_len);
            if (issue) begin
               mem_re     = 1'b1;
               rd_pend_in = 1'b1;
               rd_addr_in = mem_raddr;
               rd_last_in = (cnt_ff == scan_len - LCW'(1));
               cnt_in     = cnt_ff + LCW'(1);
            end

            if (done) begin
               state_in = (item_ff.mode == MODE_FILL) ? ST_FILL : ST_RESP;
            end
         end

         ST_FILL: begin
            mem_we             = 1'b1;
            mem_waddr          = vic_addr_ff;
            mem_wdata.valid    = 1'b1;
            mem_wdata.tag      = item_ff.tag;
            mem_wdata.stamp    = item_ff.stamp;
            mem_wdata.dirty    = item_ff.dirty_in;
            mem_wdata.frame    = item_ff.page_frame;
            mem_wdata.l1_index = item_ff.l1_index;
            mem_wdata.l1_tag   = item_ff.l1_tag;
            full_in            = !inv_ff;
            state_in           = ST_RESP;
         end

         // Hand the result to the output register once it is free.
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in              = '0;
               rsp_data_in.hit          = hit_ff;
               rsp_data_in.set_was_full = full_ff;
               if (full_ff) begin
                  rsp_data_in.victim_valid    = 1'b1;
                  rsp_data_in.victim_dirty    = vic_line_ff.dirty;
                  rsp_data_in.victim_address  = vic_address;
                  rsp_data_in.victim_l1_index = vic_line_ff.l1_index;
                  rsp_data_in.victim_l1_tag   = vic_line_ff.l1_tag;
               end
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         cnt_ff         <= '0;
         rd_pend_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         offset_bits_ff <= OFFSET_BITS_RST;
         index_bits_ff  <= INDEX_BITS_RST;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         rd_pend_ff     <= rd_pend_in;
         rsp_valid_ff   <= rsp_valid_in;
         offset_bits_ff <= offset_bits_in;
         index_bits_ff  <= index_bits_in;
      end
      base_ff     <= base_in;
      rd_addr_ff  <= rd_addr_in;
      rd_last_ff  <= rd_last_in;
      item_ff     <= item_in;
      hit_ff      <= hit_in;
      full_ff     <= full_in;
      have_ff     <= have_in;
      inv_ff      <= inv_in;
      best_ff     <= best_in;
      vic_addr_ff <= vic_addr_in;
      vic_line_ff <= vic_line_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

FILE: design/sacl_checker.sv
// Port-level checker for the LRU cache tag store, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sacl_checker (
   input wire               clock,
   input wire               reset,
   input wire               req_valid,
   input wire               req_stall,
   input sacl_pkg::req_type req_data,
   input wire               rsp_valid,
   input wire               rsp_stall,
   input sacl_pkg::rsp_type rsp_data
);
   import sacl_pkg::*;

   // The clearing pass keeps the input closed right after reset.
   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> req_stall)
      else $error("input open right after reset");

   // One item at a time: the input is closed in the cycle after an item is accepted.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item accepted back to back");

   // No result can appear in the cycle right after its item was accepted.
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
      else $error("result appeared one cycle after accept");

   // An eviction only happens from a full set and never reports a hit.
   a_victim_from_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.victim_valid |-> rsp_data.set_was_full && !rsp_data.hit)
      else $error("victim reported without a full set");

   // A stalled item holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled item changed");

endmodule

bind set_assoc_cache_tag_store_lru sacl_checker u_sacl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

FILE: dv/set_assoc_cache_tag_store_lru_test.sv
// Self-checking testbench for the LRU cache tag store: directed table, then random traffic.
`timescale 1ns / 1ps

module set_assoc_cache_tag_store_lru_test;
   import sacl_pkg::*;

   localparam int SETS = DEF_SETS;
   localparam int WAYS = DEF_WAYS;
   localparam int LINES = SETS * WAYS;
   // The slowest item is an invalidate that walks every line, plus a full stall on
   // each side; this many cycles without any transfer means the block is stuck.
   localparam int IDLE_LIMIT = 3000;
   localparam int ITEMS_PER_PHASE = 300;
   localparam int PHASES = 6;

   // One row of the directed table. Where typed is set, want is the result read
   // straight off the behavior; otherwise the result comes from the cache model.
   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Cache model: its own copy of every line and of both geometry registers.
   line_type        tag_lines [LINES];
   logic [3:0]      model_offset_bits;
   logic [3:0]      model_index_bits;
   logic [30:0]     stamp_clock;

   rsp_type         results_due [$];
   stim_row_type    directed_rows [$];
   bit              row_typed;
   rsp_type         row_want;
   bit              req_quiet;
   bit              rsp_quiet;
   int              stall_left;
   int              idle_cycles;
   int              error_count;
   int              mode_count [4];
   int              hit_count;
   int              evict_count;
   int              dirty_evict_count;
   int              full_set_count;
   int              results_checked;

   set_assoc_cache_tag_store_lru DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Applies one operation to the model's lines and returns the result it causes.
   function automatic rsp_type apply_cache_op(input req_type r);
      rsp_type     res;
      int          base;
      int          victim;
      int          k;
      bit          full;
      logic [30:0] oldest;
      logic [63:0] addr;
      int          shift_total;
      res = '0;
      base = r.set_index * WAYS;
      case (r.mode)
         MODE_INVAL: begin
            // Sets in ascending order, ways in ascending order; first match only.
            for (k = 0; k < LINES; k++) begin
               if (tag_lines[k].valid && tag_lines[k].frame == r.page_frame) begin
                  tag_lines[k] = '0;
                  res.hit = 1'b1;
                  break;
               end
            end
         end
         MODE_LOOKUP: begin
            // Every matching way is stamped, duplicates included.
            for (k = base; k < base + WAYS; k++) begin
               if (tag_lines[k].valid && tag_lines[k].tag == r.tag) begin
                  tag_lines[k].stamp = r.stamp;
                  res.hit = 1'b1;
               end
            end
         end
         MODE_DIRTY: begin
            for (k = base; k < base + WAYS; k++) begin
               if (tag_lines[k].valid && tag_lines[k].tag == r.tag) begin
                  tag_lines[k].dirty = 1'b1;
                  break;
               end
            end
         end
         default: begin
            // Fill: the first invalid way wins; in a full set the smallest stamp,
            // and the lowest way among equal stamps.
            full = 1'b1;
            victim = 0;
            for (k = 0; k < WAYS; k++) begin
               if (!tag_lines[base + k].valid) begin
                  full = 1'b0;
                  victim = k;
                  break;
               end
            end
            if (full) begin
               oldest = tag_lines[base].stamp;
               for (k = 1; k < WAYS; k++) begin
                  if (tag_lines[base + k].stamp < oldest) begin
                     oldest = tag_lines[base + k].stamp;
                     victim = k;
                  end
               end
            end
            k = base + victim;
            res.set_was_full = full;
            if (tag_lines[k].valid) begin
               shift_total = int'(model_index_bits) + int'(model_offset_bits);
               addr = (64'(tag_lines[k].tag) << shift_total)
                    | (64'(r.set_index) << model_offset_bits);
               res.victim_valid = 1'b1;
               res.victim_dirty = tag_lines[k].dirty;
               res.victim_address = addr[31:0];
               res.victim_l1_index = tag_lines[k].l1_index;
               res.victim_l1_tag = tag_lines[k].l1_tag;
            end
            tag_lines[k].valid = 1'b1;
            tag_lines[k].tag = r.tag;
            tag_lines[k].stamp = r.stamp;
            tag_lines[k].dirty = r.dirty_in;
            tag_lines[k].frame = r.page_frame;
            tag_lines[k].l1_index = r.l1_index;
            tag_lines[k].l1_tag = r.l1_tag;
         end
      endcase
      return res;
   endfunction

   function automatic req_type make_req(input logic [1:0] mode, input int set_index,
                                        input int tag, input int stamp, input int dirty,
                                        input int frame, input int l1i, input int l1t);
      req_type r;
      r.mode = mode;
      r.set_index = 4'(set_index);
      r.tag = 20'(tag);
      r.stamp = 31'(stamp);
      r.dirty_in = 1'(dirty);
      r.page_frame = 20'(frame);
      r.l1_index = 8'(l1i);
      r.l1_tag = 24'(l1t);
      return r;
   endfunction

   task automatic add_row(input req_type item, input int typed, input rsp_type want);
      stim_row_type row;
      row.item = item;
      row.typed = 1'(typed);
      row.want = want;
      directed_rows.push_back(row);
   endtask

   // Random traffic that often reuses tags and frames already in the store, so that
   // lookups hit, duplicates appear and full sets evict; the rest is small or random values.
   function automatic req_type random_item();
      req_type r;
      int      roll;
      int      way;
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
         r.mode = MODE_FILL;
      end else if (roll < 65) begin
         r.mode = MODE_LOOKUP;
      end else if (roll < 82) begin
         r.mode = MODE_DIRTY;
      end else begin
         r.mode = MODE_INVAL;
      end
      r.set_index = 4'($urandom_range(0, SETS - 1));
      way = $urandom_range(0, WAYS - 1);
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         r.tag = tag_lines[r.set_index * WAYS + way].tag;
      end else if (roll < 75) begin
         r.tag = 20'($urandom_range(0, 7));
      end else begin
         r.tag = 20'($urandom);
      end
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
         stamp_clock = stamp_clock + 31'($urandom_range(1, 64));
         r.stamp = stamp_clock;
      end else if (roll < 90) begin
         r.stamp = 31'($urandom);
      end else if (roll < 95) begin
         r.stamp = '0;
      end else begin
         r.stamp = '1;
      end
      r.dirty_in = 1'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
         r.page_frame = tag_lines[$urandom_range(0, LINES - 1)].frame;
      end else if (roll < 70) begin
         r.page_frame = 20'($urandom_range(0, 7));
      end else begin
         r.page_frame = 20'($urandom);
      end
      r.l1_index = 8'($urandom);
      r.l1_tag = 24'($urandom);
      return r;
   endfunction

   // Called at a falling edge; returns at the falling edge after the item is taken.
   // The sender sometimes runs in quiet stretches with no gaps at all.
   task automatic send_item(input req_type item, input bit typed, input rsp_type want);
      int gap;
      if ($urandom_range(0, 39) == 0) begin
         req_quiet = ~req_quiet;
      end
      gap = req_quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      row_typed = typed;
      row_want = want;
      req_data <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Stops new items and waits at a falling edge until every result is back.
   task automatic drain();
      req_valid <= 1'b0;
      while (results_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Writes both geometry registers on consecutive cycles while the block is idle.
   task automatic set_geometry(input logic [3:0] offset_bits, input logic [3:0] index_bits);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_OFFSET_BITS;
      csr_wdata <= offset_bits;
      @(negedge clock);
      csr_index <= CSR_INDEX_BITS;
      csr_wdata <= index_bits;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
         error_count++;
      end
   endtask

   // The result receiver draws a new stall length for every result it takes.
   always @(negedge clock) begin
      rsp_stall <= (stall_left > 0);
      if (stall_left > 0) begin
         stall_left--;
      end
   end

   // All transfers are observed here at the rising edge: register writes and accepted
   // items update the model, accepted results are checked against the oldest
   // expectation, and the watchdog counts edges at which nothing moved.
   always @(posedge clock) begin : observe
      rsp_type model_rsp;
      rsp_type want;
      bit      progress;
      if (!reset) begin
         progress = 1'b0;
         if (csr_wr_en) begin
            if (csr_index == CSR_OFFSET_BITS) begin
               model_offset_bits = csr_wdata;
            end else if (csr_index == CSR_INDEX_BITS) begin
               model_index_bits = csr_wdata;
            end
            progress = 1'b1;
         end
         if (req_valid && !req_stall) begin
            model_rsp = apply_cache_op(req_data);
            results_due.push_back(row_typed ? row_want : model_rsp);
            mode_count[req_data.mode]++;
            if (model_rsp.hit) hit_count++;
            if (model_rsp.set_was_full) full_set_count++;
            if (model_rsp.victim_valid) evict_count++;
            if (model_rsp.victim_dirty) dirty_evict_count++;
            progress = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               $error("result arrived with no item outstanding: 0x%0h", rsp_data);
               error_count++;
            end else begin
               want = results_due.pop_front();
               compare_field("hit", 32'(want.hit), 32'(rsp_data.hit));
               compare_field("set_was_full", 32'(want.set_was_full),
                             32'(rsp_data.set_was_full));
               compare_field("victim_valid", 32'(want.victim_valid),
                             32'(rsp_data.victim_valid));
               compare_field("victim_dirty", 32'(want.victim_dirty),
                             32'(rsp_data.victim_dirty));
               compare_field("victim_address", want.victim_address,
                             rsp_data.victim_address);
               compare_field("victim_l1_index", 32'(want.victim_l1_index),
                             32'(rsp_data.victim_l1_index));
               compare_field("victim_l1_tag", 32'(want.victim_l1_tag),
                             32'(rsp_data.victim_l1_tag));
            end
            results_checked++;
            if ($urandom_range(0, 39) == 0) begin
               rsp_quiet = ~rsp_quiet;
            end
            stall_left = rsp_quiet ? 0 : $urandom_range(0, 14);
            progress = 1'b1;
         end
         idle_cycles = progress ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("set_assoc_cache_tag_store_lru verification failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      rsp_type     no_result;
      rsp_type     hit_only;
      rsp_type     first_evict;
      logic [3:0]  phase_offset [PHASES];
      logic [3:0]  phase_index [PHASES];
      int          p;
      int          n;

      // Every input is known from time zero; reset starts high.
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      row_typed = 1'b0;
      row_want = '0;
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
      stall_left = 0;
      idle_cycles = 0;
      error_count = 0;
      hit_count = 0;
      evict_count = 0;
      dirty_evict_count = 0;
      full_set_count = 0;
      results_checked = 0;
      stamp_clock = '0;
      for (n = 0; n < 4; n++) mode_count[n] = 0;
      for (n = 0; n < LINES; n++) tag_lines[n] = '0;
      model_offset_bits = OFFSET_BITS_RST;
      model_index_bits = INDEX_BITS_RST;

      no_result = '0;
      hit_only = '0;
      hit_only.hit = 1'b1;
      // Evicting tag 1 from set 0 with the reset geometry: 1 << (4 + 6).
      first_evict = '0;
      first_evict.set_was_full = 1'b1;
      first_evict.victim_valid = 1'b1;
      first_evict.victim_address = 32'h0000_0400;

      // An empty store matches nothing, not even the all-zero tag or frame.
      add_row(make_req(MODE_LOOKUP, 0, 0, 0, 0, 0, 0, 0), 1, no_result);
      add_row(make_req(MODE_INVAL, 0, 0, 0, 0, 0, 0, 0), 1, no_result);
      add_row(make_req(MODE_DIRTY, 15, 0, 0, 0, 0, 0, 0), 1, no_result);
      // Fill set 0, all-ones line first, with a duplicated tag in ways 2 and 3.
      add_row(make_req(MODE_FILL, 0, 'hFFFFF, 'h7FFFFFFF, 1, 'hFFFFF, 'hFF, 'hFFFFFF),
              1, no_result);
      add_row(make_req(MODE_FILL, 0, 1, 'h10, 0, 1, 0, 0), 1, no_result);
      add_row(make_req(MODE_FILL, 0, 2, 'h20, 0, 2, 'h5A, 'hA5A5A5), 1, no_result);
      add_row(make_req(MODE_FILL, 0, 2, 'h30, 0, 3, 'h3C, 'h123456), 1, no_result);
      // A lookup stamps both duplicate ways; mark dirty touches only the first.
      add_row(make_req(MODE_LOOKUP, 0, 2, 'h40, 0, 0, 0, 0), 1, hit_only);
      add_row(make_req(MODE_DIRTY, 0, 2, 0, 0, 0, 0, 0), 1, no_result);
      // Full set: the oldest stamp goes first, then the lower way of a stamp tie.
      add_row(make_req(MODE_FILL, 0, 'h55555, 'h50, 0, 5, 'h11, 'h111111), 1, first_evict);
      add_row(make_req(MODE_FILL, 0, 'h0AAAA, 'h60, 1, 6, 'h22, 'h222222), 0, no_result);
      add_row(make_req(MODE_LOOKUP, 0, 'hFFFFF, 0, 0, 0, 0, 0), 1, hit_only);
      add_row(make_req(MODE_FILL, 0, 'h33333, 'h65, 0, 3, 'h44, 'h444444), 0, no_result);
      // Invalidate by frame clears one line per item, lowest line first.
      add_row(make_req(MODE_INVAL, 0, 0, 0, 0, 3, 0, 0), 1, hit_only);
      add_row(make_req(MODE_INVAL, 0, 0, 0, 0, 3, 0, 0), 1, hit_only);
      add_row(make_req(MODE_INVAL, 0, 0, 0, 0, 3, 0, 0), 1, no_result);
      // A set with holes refills the first invalid way and is not reported full.
      add_row(make_req(MODE_FILL, 0, 0, 'h70, 0, 8, 'h55, 'h555555), 0, no_result);
      add_row(make_req(MODE_FILL, 15, 'h80000, 1, 0, 'h7FFFF, 'h80, 'h800000),
              1, no_result);
      add_row(make_req(MODE_LOOKUP, 15, 'h80000, 2, 0, 0, 0, 0), 1, hit_only);
      add_row(make_req(MODE_DIRTY, 15, 'h80000, 0, 0, 0, 0, 0), 1, no_result);
      add_row(make_req(MODE_DIRTY, 7, 0, 0, 0, 0, 0, 0), 1, no_result);
      add_row(make_req(MODE_LOOKUP, 7, 'h12345, 3, 0, 0, 0, 0), 1, no_result);
      add_row(make_req(MODE_INVAL, 0, 0, 0, 0, 'h7FFFF, 0, 0), 1, hit_only);
      add_row(make_req(MODE_LOOKUP, 15, 'h80000, 4, 0, 0, 0, 0), 1, no_result);

      // Geometry per random phase: both extremes of each register, offset 12 with index 8,
      // offset 3 with index 1, one random setting, and the reset values again.
      phase_offset[0] = 4'd0;  phase_index[0] = 4'd0;
      phase_offset[1] = 4'd15; phase_index[1] = 4'd15;
      phase_offset[2] = 4'd12; phase_index[2] = 4'd8;
      phase_offset[3] = 4'd3;  phase_index[3] = 4'd1;
      phase_offset[4] = 4'($urandom_range(0, 15));
      phase_index[4] = 4'($urandom_range(0, 15));
      phase_offset[5] = OFFSET_BITS_RST; phase_index[5] = INDEX_BITS_RST;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The directed table runs on the reset geometry.
      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      end

      for (p = 0; p < PHASES; p++) begin
         drain();
         set_geometry(phase_offset[p], phase_index[p]);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_item(random_item(), 1'b0, no_result);
         end
      end

      drain();
      repeat (80) @(posedge clock);

      $display("covered %0d lookups, %0d fills, %0d invalidates, %0d mark-dirty items",
               mode_count[MODE_LOOKUP], mode_count[MODE_FILL], mode_count[MODE_INVAL],
               mode_count[MODE_DIRTY]);
      $display("%0d results checked: %0d hits, %0d full sets, %0d evictions (%0d dirty)",
               results_checked, hit_count, full_set_count, evict_count,
               dirty_evict_count);
      if (error_count == 0) begin
         $display("set_assoc_cache_tag_store_lru verification clean");
      end else begin
         $display("set_assoc_cache_tag_store_lru verification failed");
      end
      $finish;
   end

endmodule
